FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: src/nnis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nnis_pkg
// Types and constants for the nearest-neighbor image scaler.
// ----------------------------------------------------------------------------
package nnis_pkg;

    // Source image store geometry
    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;
    localparam int X_W        = $clog2(MAX_WIDTH);
    localparam int Y_W        = $clog2(MAX_HEIGHT);
    localparam int MEM_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int ADDR_W     = $clog2(MEM_DEPTH);

    // Field widths
    localparam int CRD_W  = 12;
    localparam int SRC_W  = 8;
    localparam int CH_W   = 3;
    localparam int PIX_W  = 32;
    localparam int CFG_W  = 12;
    localparam int IDX_W  = 3;
    localparam int PROD_W = CRD_W + SRC_W;
    localparam int QUO_W  = SRC_W;
    localparam int STEP_W = $clog2(QUO_W);

    // Register indexes
    localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
    localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
    localparam logic [IDX_W-1:0] REG_DST_WIDTH  = 3'd2;
    localparam logic [IDX_W-1:0] REG_DST_HEIGHT = 3'd3;
    localparam logic [IDX_W-1:0] REG_CHANNELS   = 3'd4;

    // Commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic             command;
        logic [CRD_W-1:0] coord_x;
        logic [CRD_W-1:0] coord_y;
        logic [7:0]       in_red;
        logic [7:0]       in_green;
        logic [7:0]       in_blue;
        logic [7:0]       in_alpha;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       range_error;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_DIV,
        S_RD,
        S_DONE
    } t_state;

endpackage

FILE: src/nearest_neighbor_image_scaler.sv
// Sequence: a write is stored at the edge that accepts it; a read passes
//   the multiply, the 8 divide steps, the store read and the output load;
//   a read outside the destination goes straight to the output load.
// Throughput: one write per cycle while idle; no new command until a read's
//   result is loaded. Reset: synchronous, active low; no clearing pass of the store.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_neighbor_image_scaler
// Pixel store with nearest-neighbor read mapping src = dst*src_size/dst_size.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_neighbor_image_scaler
    import nnis_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    // configuration write port
    input  logic             i_cfg_we,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    // command channel
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    // result channel
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [SRC_W-1:0] r_src_width;
    logic [SRC_W-1:0] r_src_height;
    logic [CRD_W-1:0] r_dst_width;
    logic [CRD_W-1:0] r_dst_height;
    logic [CH_W-1:0]  r_channels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= SRC_W'(MAX_WIDTH);
            r_src_height <= SRC_W'(MAX_HEIGHT);
            r_dst_width  <= '0;
            r_dst_height <= '0;
            r_channels   <= CH_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SRC_WIDTH:  r_src_width  <= i_cfg_data[SRC_W-1:0];
                REG_SRC_HEIGHT: r_src_height <= i_cfg_data[SRC_W-1:0];
                REG_DST_WIDTH:  r_dst_width  <= i_cfg_data;
                REG_DST_HEIGHT: r_dst_height <= i_cfg_data;
                REG_CHANNELS:   r_channels   <= i_cfg_data[CH_W-1:0];
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    // Effective sizes: clamp source size to [1, max], zero destination
    // means source size, channel count clamped to [1, 4].
    logic [SRC_W-1:0] sw;
    logic [SRC_W-1:0] sh;
    logic [CRD_W-1:0] dw;
    logic [CRD_W-1:0] dh;
    logic [CH_W-1:0]  ch;

    always_comb begin
        if (r_src_width == '0)
            sw = SRC_W'(1);
        else if (32'(r_src_width) > MAX_WIDTH)
            sw = SRC_W'(MAX_WIDTH);
        else
            sw = r_src_width;

        if (r_src_height == '0)
            sh = SRC_W'(1);
        else if (32'(r_src_height) > MAX_HEIGHT)
            sh = SRC_W'(MAX_HEIGHT);
        else
            sh = r_src_height;

        dw = (r_dst_width  == '0) ? CRD_W'(sw) : r_dst_width;
        dh = (r_dst_height == '0) ? CRD_W'(sh) : r_dst_height;

        if (r_channels == '0)
            ch = CH_W'(1);
        else if (r_channels > CH_W'(4))
            ch = CH_W'(4);
        else
            ch = r_channels;
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    t_state r_state;
    t_state n_state;

    logic in_accept;
    logic is_read;
    logic in_range;
    logic wr_in_src;
    logic out_free;
    logic last_step;

    // control strobes from the output decode
    logic ctl_capture;
    logic ctl_mul;
    logic ctl_div;
    logic ctl_rd;
    logic ctl_load;

    logic [STEP_W-1:0] r_step;

    assign in_accept = i_in_valid & o_in_ready;
    assign is_read   = (i_in_item.command == CMD_READ);
    assign in_range  = (i_in_item.coord_x < dw) && (i_in_item.coord_y < dh);
    assign wr_in_src = (i_in_item.coord_x < CRD_W'(sw)) && (i_in_item.coord_y < CRD_W'(sh));
    assign out_free  = !o_out_valid || i_out_ready;
    assign last_step = (r_step == '0);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept && is_read)
                    n_state = in_range ? S_MUL : S_DONE;
            end
            S_MUL:  n_state = S_DIV;
            S_DIV: begin
                if (last_step)
                    n_state = S_RD;
            end
            S_RD:   n_state = S_DONE;
            S_DONE: begin
                if (out_free)
                    n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready  = 1'b0;
        ctl_capture = 1'b0;
        ctl_mul     = 1'b0;
        ctl_div     = 1'b0;
        ctl_rd      = 1'b0;
        ctl_load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready  = 1'b1;
                ctl_capture = in_accept && is_read;
            end
            S_MUL:  ctl_mul  = 1'b1;
            S_DIV:  ctl_div  = 1'b1;
            S_RD:   ctl_rd   = 1'b1;
            S_DONE: ctl_load = out_free;
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_state <= S_IDLE;
        else
            r_state <= n_state;
    end

    // ------------------------------------------------------------------
    // Coordinate mapping: multiply, then restoring division, one quotient
    // bit per cycle for both axes side by side. The quotient stays below
    // the source size, so QUO_W bits are enough.
    // ------------------------------------------------------------------
    logic [CRD_W-1:0]  r_x;
    logic [CRD_W-1:0]  r_y;
    logic              r_err;
    logic [PROD_W-1:0] r_rem_x;
    logic [PROD_W-1:0] r_rem_y;
    logic [PROD_W-1:0] r_dv_x;
    logic [PROD_W-1:0] r_dv_y;
    logic [QUO_W-1:0]  r_q_x;
    logic [QUO_W-1:0]  r_q_y;

    logic ge_x;
    logic ge_y;

    assign ge_x = (r_rem_x >= r_dv_x);
    assign ge_y = (r_rem_y >= r_dv_y);

    always_ff @(posedge i_clk) begin
        if (ctl_capture) begin
            // hold the coordinates and the range verdict
            r_x   <= i_in_item.coord_x;
            r_y   <= i_in_item.coord_y;
            r_err <= !in_range;
        end
        if (ctl_mul) begin
            r_rem_x <= PROD_W'(r_x) * PROD_W'(sw);
            r_rem_y <= PROD_W'(r_y) * PROD_W'(sh);
            r_dv_x  <= PROD_W'({dw, {(QUO_W-1){1'b0}}});
            r_dv_y  <= PROD_W'({dh, {(QUO_W-1){1'b0}}});
            r_step  <= STEP_W'(QUO_W - 1);
        end
        if (ctl_div) begin
            // subtract the shifted divisor where it fits, shift in the bit
            if (ge_x)
                r_rem_x <= r_rem_x - r_dv_x;
            if (ge_y)
                r_rem_y <= r_rem_y - r_dv_y;
            r_q_x  <= {r_q_x[QUO_W-2:0], ge_x};
            r_q_y  <= {r_q_y[QUO_W-2:0], ge_y};
            r_dv_x <= r_dv_x >> 1;
            r_dv_y <= r_dv_y >> 1;
            r_step <= r_step - STEP_W'(1);
        end
    end

    // clamp to the last source pixel
    logic [QUO_W-1:0] sx;
    logic [QUO_W-1:0] sy;

    assign sx = (r_q_x >= QUO_W'(sw)) ? QUO_W'(sw - SRC_W'(1)) : r_q_x;
    assign sy = (r_q_y >= QUO_W'(sh)) ? QUO_W'(sh - SRC_W'(1)) : r_q_y;

    // ------------------------------------------------------------------
    // Pixel store: written at accept of an in-bounds write, read once per
    // in-range read. Red in the low byte, alpha in the high byte.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] r_mem [MEM_DEPTH];
    logic [PIX_W-1:0] r_rd_data;

    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [PIX_W-1:0]  wr_data;

    assign mem_we  = in_accept && !is_read && wr_in_src;
    assign wr_addr = ADDR_W'(32'(i_in_item.coord_y[Y_W-1:0]) * MAX_WIDTH
                             + 32'(i_in_item.coord_x[X_W-1:0]));
    assign rd_addr = ADDR_W'(32'(sy[Y_W-1:0]) * MAX_WIDTH + 32'(sx[X_W-1:0]));
    assign wr_data = {i_in_item.in_alpha, i_in_item.in_blue,
                      i_in_item.in_green, i_in_item.in_red};

    always_ff @(posedge i_clk) begin
        if (mem_we)
            r_mem[wr_addr] <= wr_data;
        if (ctl_rd)
            r_rd_data <= r_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Output register: lets the next command in while a result waits.
    // ------------------------------------------------------------------
    t_out_item r_out_item;
    logic      r_out_valid;
    t_out_item load_item;

    always_comb begin
        load_item             = '0;
        load_item.range_error = r_err;
        if (!r_err) begin
            load_item.out_red   = r_rd_data[7:0];
            load_item.out_green = (ch > CH_W'(1)) ? r_rd_data[15:8]  : 8'd0;
            load_item.out_blue  = (ch > CH_W'(2)) ? r_rd_data[23:16] : 8'd0;
            load_item.out_alpha = (ch > CH_W'(3)) ? r_rd_data[31:24] : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ctl_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl_load)
            r_out_item <= load_item;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_read_starts, i_clk, i_rst_n, in_accept && is_read, (r_state == S_MUL) || (r_state == S_DONE))
    `ASSERT_IMPLY(a_quot_in_src, i_clk, i_rst_n, (r_state == S_RD), (r_q_x < QUO_W'(sw)) && (r_q_y < QUO_W'(sh)))
    `ASSERT_NEXT(a_no_overwrite, i_clk, i_rst_n, (r_state == S_DONE) && o_out_valid && !i_out_ready, (r_state == S_DONE) && o_out_valid)
    `ASSERT_IMPLY(a_err_zero, i_clk, i_rst_n, o_out_valid && o_out_item.range_error, (o_out_item.out_red == 8'd0) && (o_out_item.out_alpha == 8'd0))

endmodule
